// ===== rtl/qmr_pkg.sv =====
// Shared widths, types, command and status codes for the quaternion unit.
// Used by qmr_term_mac and quaternion_multiply_rotate_unit; no dependencies.
`timescale 1ns / 1ps

package qmr_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // full product, sum of four products, sum after the fraction shift
    localparam int PROD_W = 2 * WORD_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int S2_W   = SUM_W - FRAC_BITS;

    // cross product difference and its shifted value
    localparam int CD_W   = PROD_W + 1;
    localparam int C_W    = CD_W - FRAC_BITS;

    // split of a cross term into a signed high word and an unsigned low part
    localparam int CL_W   = C_W - WORD_BITS;
    localparam int LO_W   = CL_W + 1 + WORD_BITS;
    localparam int TERM_W = C_W + WORD_BITS;
    localparam int TSUM_W = TERM_W + 2;
    localparam int T_W    = TSUM_W - FRAC_BITS;

    // widest value before saturation: v + 2*t
    localparam int FIN_W  = T_W + 2;

    localparam logic [1:0] CMD_PROD  = 2'd0;
    localparam logic [1:0] CMD_ROT   = 2'd1;
    localparam logic [1:0] CMD_SCALE = 2'd2;
    localparam logic [1:0] CMD_INV   = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_INV = 2'd2;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [SUM_W-1:0]     t_sum;
    typedef logic signed [S2_W-1:0]      t_s2;
    typedef logic signed [CD_W-1:0]      t_cd;
    typedef logic signed [C_W-1:0]       t_cw;
    typedef logic signed [CL_W:0]        t_clo;
    typedef logic signed [LO_W-1:0]      t_lo;
    typedef logic signed [TERM_W-1:0]    t_term;
    typedef logic signed [TSUM_W-1:0]    t_tsum;
    typedef logic signed [T_W-1:0]       t_tw;
    typedef logic signed [FIN_W-1:0]     t_fin;

    typedef struct packed {
        logic                 over;
        logic [WORD_BITS-1:0] val;
    } t_sat;

    function automatic t_sat sat_word(input t_fin v);
        t_sat s;
        s.over = !((v[FIN_W-1:WORD_BITS-1] == '0) || (v[FIN_W-1:WORD_BITS-1] == '1));
        if (s.over) begin
            s.val = v[FIN_W-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                               : {1'b0, {(WORD_BITS-1){1'b1}}};
        end else begin
            s.val = v[WORD_BITS-1:0];
        end
        return s;
    endfunction

endpackage

// ===== rtl/qmr_term_mac.sv =====
// Three-stage sum of products c0*m0 + c1*m1 - c2*m2, shifted by the fraction bits.
// Each wide cross term is split into two word-sized multiplies; depends on qmr_pkg.
`timescale 1ns / 1ps

module qmr_term_mac (
    input  logic           i_clk,
    input  qmr_pkg::t_cw   i_c0,
    input  qmr_pkg::t_cw   i_c1,
    input  qmr_pkg::t_cw   i_c2,
    input  qmr_pkg::t_word i_m0,
    input  qmr_pkg::t_word i_m1,
    input  qmr_pkg::t_word i_m2,
    output qmr_pkg::t_tw   o_t
);

    qmr_pkg::t_cw   w_c   [3];
    qmr_pkg::t_word w_m   [3];
    qmr_pkg::t_word w_hi  [3];
    qmr_pkg::t_clo  w_lo  [3];
    qmr_pkg::t_prod r_hi  [3];
    qmr_pkg::t_lo   r_lo  [3];
    qmr_pkg::t_term r_term[3];
    qmr_pkg::t_tsum n_sum;
    qmr_pkg::t_tw   r_t;

    assign w_c[0] = i_c0;
    assign w_c[1] = i_c1;
    assign w_c[2] = i_c2;
    assign w_m[0] = i_m0;
    assign w_m[1] = i_m1;
    assign w_m[2] = i_m2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_hi[k] = w_c[k][qmr_pkg::C_W-1:qmr_pkg::CL_W];
            w_lo[k] = {1'b0, w_c[k][qmr_pkg::CL_W-1:0]};
        end
    end

    // partial products, then recombine, then sum and drop the fraction
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_hi[k]   <= w_hi[k] * w_m[k];
            r_lo[k]   <= w_lo[k] * w_m[k];
            r_term[k] <= (qmr_pkg::t_term'(r_hi[k]) <<< qmr_pkg::CL_W)
                         + qmr_pkg::t_term'(r_lo[k]);
        end
        r_t <= qmr_pkg::t_tw'(n_sum >>> qmr_pkg::FRAC_BITS);
    end

    assign n_sum = qmr_pkg::t_tsum'(r_term[0]) + qmr_pkg::t_tsum'(r_term[1])
                 - qmr_pkg::t_tsum'(r_term[2]);

    assign o_t = r_t;

endmodule

// ===== rtl/quaternion_multiply_rotate_unit.sv =====
// Top level of the quaternion multiply / rotate unit: operand products, sums,
// rotation terms and saturation; depends on qmr_pkg and qmr_term_mac.
`timescale 1ns / 1ps

// The unit takes one command beat in every clock cycle: busy is always low, so
// start alone accepts a beat. Each beat gives exactly one result, strobed by
// o_valid for one cycle. The pipeline has six registers: the sixteen operand
// products, their sums, the split multiplies of the rotation's second cross
// product (three stages), and the final add and saturation. Results leave in
// accept order and cannot be held off.

module quaternion_multiply_rotate_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [1:0]     i_cmd,
    input  qmr_pkg::t_word i_a_x,
    input  qmr_pkg::t_word i_a_y,
    input  qmr_pkg::t_word i_a_z,
    input  qmr_pkg::t_word i_a_w,
    input  qmr_pkg::t_word i_op_x,
    input  qmr_pkg::t_word i_op_y,
    input  qmr_pkg::t_word i_op_z,
    input  qmr_pkg::t_word i_op_w,
    output logic           o_valid,
    output qmr_pkg::t_word o_res_x,
    output qmr_pkg::t_word o_res_y,
    output qmr_pkg::t_word o_res_z,
    output qmr_pkg::t_word o_res_w,
    output logic [1:0]     o_status
);

    qmr_pkg::t_word w_a [4];
    qmr_pkg::t_word w_b [4];

    logic           r1_valid;
    logic [1:0]     r1_cmd;
    qmr_pkg::t_prod r1_p [4][4];
    qmr_pkg::t_word r1_a [4];
    qmr_pkg::t_word r1_b [3];

    logic           r2_valid;
    logic [1:0]     r2_cmd;
    qmr_pkg::t_s2   r2_val [4];
    qmr_pkg::t_cw   r2_c [3];
    qmr_pkg::t_word r2_a [4];
    qmr_pkg::t_word r2_b [3];
    qmr_pkg::t_s2   n2_val [4];
    qmr_pkg::t_cw   n2_c [3];

    logic           r_d_valid [3];
    logic [1:0]     r_d_cmd [3];
    qmr_pkg::t_s2   r_d_val [3][4];
    qmr_pkg::t_word r_d_b [3][3];

    qmr_pkg::t_tw   w_t [3];

    qmr_pkg::t_fin  n_fin [4];
    qmr_pkg::t_sat  n_sat [4];
    logic [1:0]     n_status;

    logic           r_valid;
    qmr_pkg::t_word r_res [4];
    logic [1:0]     r_status;

    assign busy = 1'b0;

    assign w_a[0] = i_a_x;
    assign w_a[1] = i_a_y;
    assign w_a[2] = i_a_z;
    assign w_a[3] = i_a_w;
    assign w_b[0] = i_op_x;
    assign w_b[1] = i_op_y;
    assign w_b[2] = i_op_z;
    assign w_b[3] = i_op_w;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            for (int s = 0; s < 3; s++) begin
                r_d_valid[s] <= 1'b0;
            end
            r_valid <= 1'b0;
        end else begin
            r1_valid     <= start && !busy;
            r2_valid     <= r1_valid;
            r_d_valid[0] <= r2_valid;
            for (int s = 1; s < 3; s++) begin
                r_d_valid[s] <= r_d_valid[s-1];
            end
            r_valid <= r_d_valid[2];
        end
    end

    // stage 2: sums of products (scaled terms for scale) and the first cross product
    always_comb begin
        n2_c[0] = qmr_pkg::t_cw'((qmr_pkg::t_cd'(r1_p[1][2]) - qmr_pkg::t_cd'(r1_p[2][1]))
                  >>> qmr_pkg::FRAC_BITS);
        n2_c[1] = qmr_pkg::t_cw'((qmr_pkg::t_cd'(r1_p[2][0]) - qmr_pkg::t_cd'(r1_p[0][2]))
                  >>> qmr_pkg::FRAC_BITS);
        n2_c[2] = qmr_pkg::t_cw'((qmr_pkg::t_cd'(r1_p[0][1]) - qmr_pkg::t_cd'(r1_p[1][0]))
                  >>> qmr_pkg::FRAC_BITS);
        case (r1_cmd)
            qmr_pkg::CMD_SCALE: begin
                for (int k = 0; k < 4; k++) begin
                    n2_val[k] = qmr_pkg::t_s2'(r1_p[k][0] >>> qmr_pkg::FRAC_BITS);
                end
            end
            default: begin
                n2_val[0] = qmr_pkg::t_s2'((qmr_pkg::t_sum'(r1_p[3][0])
                            + qmr_pkg::t_sum'(r1_p[0][3]) + qmr_pkg::t_sum'(r1_p[1][2])
                            - qmr_pkg::t_sum'(r1_p[2][1])) >>> qmr_pkg::FRAC_BITS);
                n2_val[1] = qmr_pkg::t_s2'((qmr_pkg::t_sum'(r1_p[3][1])
                            - qmr_pkg::t_sum'(r1_p[0][2]) + qmr_pkg::t_sum'(r1_p[1][3])
                            + qmr_pkg::t_sum'(r1_p[2][0])) >>> qmr_pkg::FRAC_BITS);
                n2_val[2] = qmr_pkg::t_s2'((qmr_pkg::t_sum'(r1_p[3][2])
                            + qmr_pkg::t_sum'(r1_p[0][1]) - qmr_pkg::t_sum'(r1_p[1][0])
                            + qmr_pkg::t_sum'(r1_p[2][3])) >>> qmr_pkg::FRAC_BITS);
                n2_val[3] = qmr_pkg::t_s2'((qmr_pkg::t_sum'(r1_p[3][3])
                            - qmr_pkg::t_sum'(r1_p[0][0]) - qmr_pkg::t_sum'(r1_p[1][1])
                            - qmr_pkg::t_sum'(r1_p[2][2])) >>> qmr_pkg::FRAC_BITS);
            end
        endcase
    end

    // payload: products, sums, the delay line beside the term pipeline, and results
    always_ff @(posedge i_clk) begin
        r1_cmd <= i_cmd;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                r1_p[i][j] <= w_a[i] * w_b[j];
            end
            r1_a[i] <= w_a[i];
        end
        for (int k = 0; k < 3; k++) begin
            r1_b[k] <= w_b[k];
        end

        r2_cmd <= r1_cmd;
        for (int k = 0; k < 4; k++) begin
            r2_val[k] <= n2_val[k];
            r2_a[k]   <= r1_a[k];
        end
        for (int k = 0; k < 3; k++) begin
            r2_c[k] <= n2_c[k];
            r2_b[k] <= r1_b[k];
        end

        r_d_cmd[0] <= r2_cmd;
        for (int k = 0; k < 4; k++) begin
            r_d_val[0][k] <= r2_val[k];
        end
        for (int k = 0; k < 3; k++) begin
            r_d_b[0][k] <= r2_b[k];
        end
        for (int s = 1; s < 3; s++) begin
            r_d_cmd[s] <= r_d_cmd[s-1];
            for (int k = 0; k < 4; k++) begin
                r_d_val[s][k] <= r_d_val[s-1][k];
            end
            for (int k = 0; k < 3; k++) begin
                r_d_b[s][k] <= r_d_b[s-1][k];
            end
        end

        for (int k = 0; k < 4; k++) begin
            r_res[k] <= $signed(n_sat[k].val);
        end
        r_status <= n_status;
    end

    // t = c*w + u x c, one unit per component
    qmr_term_mac u_term_x (
        .i_clk (i_clk),
        .i_c0  (r2_c[0]), .i_m0 (r2_a[3]),
        .i_c1  (r2_c[2]), .i_m1 (r2_a[1]),
        .i_c2  (r2_c[1]), .i_m2 (r2_a[2]),
        .o_t   (w_t[0])
    );

    qmr_term_mac u_term_y (
        .i_clk (i_clk),
        .i_c0  (r2_c[1]), .i_m0 (r2_a[3]),
        .i_c1  (r2_c[0]), .i_m1 (r2_a[2]),
        .i_c2  (r2_c[2]), .i_m2 (r2_a[0]),
        .o_t   (w_t[1])
    );

    qmr_term_mac u_term_z (
        .i_clk (i_clk),
        .i_c0  (r2_c[2]), .i_m0 (r2_a[3]),
        .i_c1  (r2_c[1]), .i_m1 (r2_a[0]),
        .i_c2  (r2_c[0]), .i_m2 (r2_a[1]),
        .o_t   (w_t[2])
    );

    // final select, add and saturate
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_fin[k] = '0;
        end
        case (r_d_cmd[2])
            qmr_pkg::CMD_PROD, qmr_pkg::CMD_SCALE: begin
                for (int k = 0; k < 4; k++) begin
                    n_fin[k] = qmr_pkg::t_fin'(r_d_val[2][k]);
                end
            end
            qmr_pkg::CMD_ROT: begin
                for (int k = 0; k < 3; k++) begin
                    n_fin[k] = qmr_pkg::t_fin'(r_d_b[2][k])
                             + (qmr_pkg::t_fin'(w_t[k]) <<< 1);
                end
            end
            default: begin
                for (int k = 0; k < 4; k++) begin
                    n_fin[k] = '0;
                end
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            n_sat[k] = qmr_pkg::sat_word(n_fin[k]);
        end
        if (r_d_cmd[2] == qmr_pkg::CMD_INV) begin
            n_status = qmr_pkg::ST_INV;
        end else if (n_sat[0].over || n_sat[1].over || n_sat[2].over || n_sat[3].over) begin
            n_status = qmr_pkg::ST_SAT;
        end else begin
            n_status = qmr_pkg::ST_OK;
        end
    end

    assign o_valid  = r_valid;
    assign o_res_x  = r_res[0];
    assign o_res_y  = r_res[1];
    assign o_res_z  = r_res[2];
    assign o_res_w  = r_res[3];
    assign o_status = r_status;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##6 o_valid)
        else $error("accepted beat did not produce a result after six cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, 6))
        else $error("result strobe without an accepted beat");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == qmr_pkg::ST_INV |->
            o_res_x == '0 && o_res_y == '0 && o_res_z == '0 && o_res_w == '0)
        else $error("invalid command returned nonzero components");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for quaternion_multiply_rotate_unit: product, rotation,
// scaling and invalid commands, checked against a Q16.16 predictor.
// Depends on rtl/qmr_pkg.sv and rtl/quaternion_multiply_rotate_unit.sv.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 410;
    localparam int ONE             = 32'sh0001_0000;
    localparam int MAX_W           = 32'sh7FFF_FFFF;
    localparam int MIN_W           = 32'sh8000_0000;

    typedef struct {
        logic [1:0]     cmd;
        qmr_pkg::t_word a  [4];
        qmr_pkg::t_word op [4];
    } quat_beat_t;

    typedef struct {
        qmr_pkg::t_word comp [4];
        logic [1:0]     status;
    } quat_result_t;

    class quat_checker;
        quat_result_t pending_results[$];
        int           errors = 0;
        string        comp_name [4] = '{"x", "y", "z", "w"};

        function quat_result_t quat_compute(quat_beat_t b);
            logic signed [127:0] ax, ay, az, aw, bx, by, bz, bw;
            logic signed [127:0] cx, cy, cz, tx, ty, tz;
            logic signed [127:0] full [4];
            quat_result_t        r;
            logic                over;
            int                  i;
            ax = b.a[0];  ay = b.a[1];  az = b.a[2];  aw = b.a[3];
            bx = b.op[0]; by = b.op[1]; bz = b.op[2]; bw = b.op[3];
            over = 1'b0;
            case (b.cmd)
                qmr_pkg::CMD_PROD: begin
                    full[0] = (aw * bx + ax * bw + ay * bz - az * by) >>> qmr_pkg::FRAC_BITS;
                    full[1] = (aw * by - ax * bz + ay * bw + az * bx) >>> qmr_pkg::FRAC_BITS;
                    full[2] = (aw * bz + ax * by - ay * bx + az * bw) >>> qmr_pkg::FRAC_BITS;
                    full[3] = (aw * bw - ax * bx - ay * by - az * bz) >>> qmr_pkg::FRAC_BITS;
                end
                qmr_pkg::CMD_ROT: begin
                    cx = (ay * bz - az * by) >>> qmr_pkg::FRAC_BITS;
                    cy = (az * bx - ax * bz) >>> qmr_pkg::FRAC_BITS;
                    cz = (ax * by - ay * bx) >>> qmr_pkg::FRAC_BITS;
                    tx = (cx * aw + ay * cz - az * cy) >>> qmr_pkg::FRAC_BITS;
                    ty = (cy * aw + az * cx - ax * cz) >>> qmr_pkg::FRAC_BITS;
                    tz = (cz * aw + ax * cy - ay * cx) >>> qmr_pkg::FRAC_BITS;
                    full[0] = bx + tx + tx;
                    full[1] = by + ty + ty;
                    full[2] = bz + tz + tz;
                    full[3] = '0;
                end
                qmr_pkg::CMD_SCALE: begin
                    full[0] = (ax * bx) >>> qmr_pkg::FRAC_BITS;
                    full[1] = (ay * bx) >>> qmr_pkg::FRAC_BITS;
                    full[2] = (az * bx) >>> qmr_pkg::FRAC_BITS;
                    full[3] = (aw * bx) >>> qmr_pkg::FRAC_BITS;
                end
                default: begin
                    for (i = 0; i < 4; i++) r.comp[i] = '0;
                    r.status = qmr_pkg::ST_INV;
                    return r;
                end
            endcase
            for (i = 0; i < 4; i++) begin
                if (full[i][127:qmr_pkg::WORD_BITS-1] != '0
                        && full[i][127:qmr_pkg::WORD_BITS-1] != '1) begin
                    over      = 1'b1;
                    r.comp[i] = full[i][127] ? MIN_W : MAX_W;
                end else begin
                    r.comp[i] = full[i][qmr_pkg::WORD_BITS-1:0];
                end
            end
            r.status = over ? qmr_pkg::ST_SAT : qmr_pkg::ST_OK;
            return r;
        endfunction

        function void note_command(quat_beat_t b);
            pending_results.push_back(quat_compute(b));
        endfunction

        function void check_result(quat_result_t got);
            quat_result_t want;
            int           i;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, status %0d", $time, got.status);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            for (i = 0; i < 4; i++) begin
                if (got.comp[i] !== want.comp[i]) begin
                    $display("%0t: res_%s mismatch: expected %h actual %h",
                             $time, comp_name[i], want.comp[i], got.comp[i]);
                    errors++;
                end
            end
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    quat_beat_t     beat;
    logic           o_valid;
    qmr_pkg::t_word o_res_x, o_res_y, o_res_z, o_res_w;
    logic [1:0]     o_status;

    quat_checker    board;
    quat_result_t   seen;
    int             idle_pct;
    int             quiet_cycles;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    quaternion_multiply_rotate_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (beat.cmd),
        .i_a_x    (beat.a[0]),
        .i_a_y    (beat.a[1]),
        .i_a_z    (beat.a[2]),
        .i_a_w    (beat.a[3]),
        .i_op_x   (beat.op[0]),
        .i_op_y   (beat.op[1]),
        .i_op_z   (beat.op[2]),
        .i_op_w   (beat.op[3]),
        .o_valid  (o_valid),
        .o_res_x  (o_res_x),
        .o_res_y  (o_res_y),
        .o_res_z  (o_res_z),
        .o_res_w  (o_res_w),
        .o_status (o_status)
    );

    function automatic quat_beat_t make_beat(logic [1:0] cmd, int ax, int ay, int az, int aw,
                                             int bx, int by, int bz, int bw);
        quat_beat_t b;
        b.cmd   = cmd;
        b.a[0]  = ax; b.a[1]  = ay; b.a[2]  = az; b.a[3]  = aw;
        b.op[0] = bx; b.op[1] = by; b.op[2] = bz; b.op[3] = bw;
        return b;
    endfunction

    function automatic qmr_pkg::t_word rand_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return int'($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
        if (pick < 55) return int'($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
        if (pick < 85) return $urandom;
        case ($urandom_range(0, 5))
            0:       return MAX_W;
            1:       return MIN_W;
            2:       return 0;
            3:       return 1;
            4:       return -1;
            default: return ONE;
        endcase
    endfunction

    function automatic quat_beat_t rand_beat();
        quat_beat_t b;
        int         i;
        b.cmd = ($urandom_range(0, 9) == 0) ? qmr_pkg::CMD_INV : 2'($urandom_range(0, 2));
        for (i = 0; i < 4; i++) begin
            b.a[i]  = rand_word();
            b.op[i] = rand_word();
        end
        return b;
    endfunction

    task automatic send_command(input quat_beat_t b);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            beat  <= rand_beat();
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start <= 1'b1;
        beat  <= b;
        do @(posedge i_clk); while (busy);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            board.note_command(beat);
        end
        if (i_rst_n && o_valid) begin
            seen.comp[0] = o_res_x;
            seen.comp[1] = o_res_y;
            seen.comp[2] = o_res_z;
            seen.comp[3] = o_res_w;
            seen.status  = o_status;
            board.check_result(seen);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, board.pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int phase;
        int phase_idle [4];
        phase_idle   = '{0, 79, 0, 13};
        board        = new;
        idle_pct     = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        beat        <= make_beat(qmr_pkg::CMD_PROD, 0, 0, 0, 0, 0, 0, 0, 0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(make_beat(qmr_pkg::CMD_PROD, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_beat(qmr_pkg::CMD_PROD, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_command(make_beat(qmr_pkg::CMD_PROD, ONE, 0, 0, 0, 0, ONE, 0, 0));
        send_command(make_beat(qmr_pkg::CMD_PROD, MAX_W, MAX_W, MAX_W, MAX_W,
                               MAX_W, MAX_W, MAX_W, MAX_W));
        send_command(make_beat(qmr_pkg::CMD_PROD, MIN_W, MIN_W, MIN_W, MIN_W,
                               MIN_W, MIN_W, MIN_W, MIN_W));
        send_command(make_beat(qmr_pkg::CMD_PROD, MAX_W, MIN_W, MAX_W, MIN_W,
                               MIN_W, MAX_W, MIN_W, MAX_W));
        send_command(make_beat(qmr_pkg::CMD_PROD, -1, 0, 0, 0, 0, 0, 0, 1));
        send_command(make_beat(qmr_pkg::CMD_ROT, 0, 0, 0, ONE, ONE, 2 * ONE, 3 * ONE, 0));
        send_command(make_beat(qmr_pkg::CMD_ROT, 0, 0, 32'sh0000B505, 32'sh0000B505,
                               ONE, 0, 0, 0));
        send_command(make_beat(qmr_pkg::CMD_ROT, ONE, -ONE, ONE, ONE, ONE, ONE, -ONE,
                               $urandom));
        send_command(make_beat(qmr_pkg::CMD_ROT, MAX_W, MAX_W, MAX_W, MAX_W,
                               MAX_W, MAX_W, MAX_W, MAX_W));
        send_command(make_beat(qmr_pkg::CMD_ROT, MIN_W, MIN_W, MIN_W, MIN_W,
                               MIN_W, MIN_W, MIN_W, MIN_W));
        send_command(make_beat(qmr_pkg::CMD_ROT, -1, -1, -1, -1, -1, 1, -1, -1));
        send_command(make_beat(qmr_pkg::CMD_SCALE, MAX_W, MIN_W, 0, -1, ONE, 0, 0, 0));
        send_command(make_beat(qmr_pkg::CMD_SCALE, MIN_W, MAX_W, ONE, -ONE, -ONE,
                               $urandom, $urandom, $urandom));
        send_command(make_beat(qmr_pkg::CMD_SCALE, MAX_W, MIN_W, MAX_W, MIN_W, MAX_W,
                               MIN_W, MAX_W, MIN_W));
        send_command(make_beat(qmr_pkg::CMD_SCALE, -1, 1, -1, 1, 1, -1, -1, -1));
        send_command(make_beat(qmr_pkg::CMD_INV, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_beat(qmr_pkg::CMD_INV, -1, -1, -1, -1, -1, -1, -1, -1));
        send_command(make_beat(qmr_pkg::CMD_INV, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom));

        for (phase = 0; phase < 4; phase++) begin
            idle_pct = phase_idle[phase];
            repeat (ITEMS_PER_PHASE) send_command(rand_beat());
        end
        start <= 1'b0;

        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== quaternion_multiply_rotate_unit.f =====
rtl/qmr_pkg.sv
rtl/qmr_term_mac.sv
rtl/quaternion_multiply_rotate_unit.sv
tb/testbench.sv
